@@ hw/rtl/hhdm_pkg.sv @@
// Shared types and constants for the heading-hold drive mixer.
// Holds payload structs, mode and register-index codes, and derived widths.
// No dependencies.
package hhdm_pkg;

	// Field widths
	localparam int THROTTLE_BITS  = 16;
	localparam int HEADING_BITS   = 24;
	localparam int YAW_BITS       = 20;
	localparam int GAIN_BITS      = 16;
	localparam int RATIO_BITS     = 16;
	localparam int DEADBAND_BITS  = 15;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// Fixed-point fraction bits
	localparam int TFRAC      = THROTTLE_BITS - 1;
	localparam int RAW_FRAC   = 21;
	localparam int RATIO_FRAC = 15;
	localparam int DB_FRAC    = 15;

	// Datapath widths
	localparam int ERR_BITS    = HEADING_BITS + 1;
	localparam int P_BITS      = ERR_BITS + GAIN_BITS + 1;
	localparam int D_BITS      = YAW_BITS + GAIN_BITS + 1;
	localparam int RAW_BITS    = ((P_BITS > D_BITS) ? P_BITS : D_BITS) + 1;
	localparam int SHL         = (TFRAC > RAW_FRAC) ? (TFRAC - RAW_FRAC) : 0;
	localparam int SHR         = (TFRAC > RAW_FRAC) ? 0 : (RAW_FRAC - TFRAC);
	localparam int TURN_BITS   = RAW_BITS + SHL;
	localparam int MC_BITS     = THROTTLE_BITS + RATIO_BITS;
	localparam int MAXC_BITS   = THROTTLE_BITS + 1;
	localparam int CLAMP_BITS  = THROTTLE_BITS + 2;
	localparam int SUM_BITS    = THROTTLE_BITS + 3;
	localparam int CMP_BITS    = THROTTLE_BITS + DB_FRAC + 1;

	// Full scale and correction floor (0.10 of full scale, rounded)
	localparam logic [63:0] ONE_FS = 64'd1 << TFRAC;
	localparam logic signed [THROTTLE_BITS-1:0] FULL_SCALE =
		THROTTLE_BITS'(ONE_FS - 64'd1);
	localparam logic [MAXC_BITS-1:0] FLOOR_CORR = MAXC_BITS'((ONE_FS + 64'd5) / 64'd10);

	// Register reset values
	localparam logic [RATIO_BITS-1:0]    CORR_RATIO_RESET = RATIO_BITS'(32768);
	localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET   = DEADBAND_BITS'(3277);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_HOLD = 2'd1,
		MODE_SAME = 2'd2
	} hhdm_mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PROP_GAIN  = 2'd0,
		CFG_DERIV_GAIN = 2'd1,
		CFG_CORR_RATIO = 2'd2,
		CFG_DEADBAND   = 2'd3
	} hhdm_cfg_t;

	typedef struct packed {
		logic signed [THROTTLE_BITS-1:0] forward_throttle;
		logic                            straight_request;
		logic                            half_power;
		logic                            sensor_ready;
		logic signed [HEADING_BITS-1:0]  heading_now;
		logic signed [YAW_BITS-1:0]      yaw_rate;
	} hhdm_in_t;

	typedef struct packed {
		logic signed [THROTTLE_BITS-1:0] left_drive;
		logic signed [THROTTLE_BITS-1:0] right_drive;
		logic [1:0]                      drive_mode;
	} hhdm_out_t;

	// One classified item, as handed from front to back
	typedef struct packed {
		logic signed [THROTTLE_BITS-1:0] fwd;
		logic [THROTTLE_BITS-1:0]        mag;
		logic signed [ERR_BITS-1:0]      err;
		logic signed [YAW_BITS-1:0]      yaw;
		logic                            half;
		hhdm_mode_t                      mode;
	} hhdm_cmd_t;

	typedef struct packed {
		logic      push;
		hhdm_cmd_t cmd;
	} hhdm_push_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]  prop_gain;
		logic [GAIN_BITS-1:0]  deriv_gain;
		logic [RATIO_BITS-1:0] correction_ratio;
	} hhdm_gains_t;

endpackage

@@ hw/rtl/hhdm_front.sv @@
// Front end of the drive mixer: deadband, mode machine and target latch.
// Classifies each item and pushes those that give a result. Uses hhdm_pkg.
module hhdm_front
	import hhdm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  hhdm_in_t                 cmd,
	input  logic [DEADBAND_BITS-1:0] deadband_level,
	input  logic                     q_full,
	output hhdm_push_t               push
);

	hhdm_mode_t                     mode_q, mode_d;
	logic signed [HEADING_BITS-1:0] target_q, target_eff;
	logic                           accept, load_target;
	logic [THROTTLE_BITS-1:0]       mag_raw, mag_db;
	logic signed [THROTTLE_BITS-1:0] fwd_db;
	logic [CMP_BITS-1:0]            cmp_lhs, cmp_rhs;

	assign cmd_ready = !q_full;
	assign accept    = cmd_valid && !q_full;

	// Deadband on an exact compare of the two fractions
	always_comb begin
		mag_raw = cmd.forward_throttle[THROTTLE_BITS-1]
			? (~THROTTLE_BITS'(cmd.forward_throttle) + THROTTLE_BITS'(1))
			: THROTTLE_BITS'(cmd.forward_throttle);
		cmp_lhs = CMP_BITS'(mag_raw) << DB_FRAC;
		cmp_rhs = CMP_BITS'(deadband_level) << TFRAC;
		if (cmp_lhs <= cmp_rhs) begin
			fwd_db = '0;
			mag_db = '0;
		end else begin
			fwd_db = cmd.forward_throttle;
			mag_db = mag_raw;
		end
	end

	// Next mode
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_HOLD: begin
				if (!cmd.straight_request)
					mode_d = MODE_OFF;
				else if (!cmd.sensor_ready)
					mode_d = MODE_SAME;
			end
			MODE_SAME: begin
				if (!cmd.straight_request)
					mode_d = MODE_OFF;
			end
			default: begin
				if (!cmd.straight_request)
					mode_d = MODE_OFF;
				else if (!cmd.sensor_ready)
					mode_d = MODE_SAME;
				else
					mode_d = MODE_HOLD;
			end
		endcase
	end

	// Outputs of the mode machine
	always_comb begin
		load_target   = (mode_d == MODE_HOLD) && (mode_q != MODE_HOLD);
		target_eff    = load_target ? cmd.heading_now : target_q;
		push.push     = accept && cmd.straight_request;
		push.cmd.fwd  = fwd_db;
		push.cmd.mag  = mag_db;
		push.cmd.err  = ERR_BITS'(target_eff) - ERR_BITS'(cmd.heading_now);
		push.cmd.yaw  = cmd.yaw_rate;
		push.cmd.half = cmd.half_power;
		push.cmd.mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			target_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			if (load_target)
				target_q <= cmd.heading_now;
		end
	end

endmodule

@@ hw/rtl/hhdm_queue.sv @@
// Short command queue between front and back of the drive mixer.
// Register-based FIFO of hhdm_cmd_t entries. Uses hhdm_pkg.
module hhdm_queue
	import hhdm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  hhdm_push_t push,
	input  logic       pop,
	output logic       q_full,
	output logic       q_valid,
	output hhdm_cmd_t  q_cmd
);

	hhdm_cmd_t            entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push, do_pop;

	assign q_full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];
	assign do_push = push.push && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + QPTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + QPTR_BITS'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_BITS'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_BITS'(1);
		end
	end

endmodule

@@ hw/rtl/hhdm_back.sv @@
// Back end of the drive mixer: PD correction, cap, mix, saturate, halve.
// Three-stage pipeline with per-stage stall. Uses hhdm_pkg.
module hhdm_back
	import hhdm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  hhdm_cmd_t   q_cmd,
	output logic        pop,
	input  hhdm_gains_t gains,
	output logic        drv_valid,
	input  logic        drv_ready,
	output hhdm_out_t   drv
);

	logic adv1, adv2, adv3;
	logic v1_s1, v2_s2, v3_s3;

	// Stage 1: products
	logic signed [P_BITS-1:0]        p_s1;
	logic signed [D_BITS-1:0]        d_s1;
	logic [MC_BITS-1:0]              mc_s1;
	logic signed [THROTTLE_BITS-1:0] fwd_s1;
	logic                            half_s1;
	hhdm_mode_t                      mode_s1;

	// Stage 2: capped correction
	logic signed [RAW_BITS-1:0]      raw;
	logic signed [TURN_BITS-1:0]     turn_w, maxc_w;
	logic [MAXC_BITS-1:0]            maxc;
	logic signed [CLAMP_BITS-1:0]    turn_c;
	logic signed [CLAMP_BITS-1:0]    turn_s2;
	logic signed [THROTTLE_BITS-1:0] fwd_s2;
	logic                            half_s2;
	hhdm_mode_t                      mode_s2;

	// Stage 3: mix
	logic signed [SUM_BITS-1:0]      sum_l, sum_r;
	logic signed [THROTTLE_BITS-1:0] sat_l, sat_r, half_l, half_r;
	hhdm_out_t                       drv_s3;

	assign adv3      = !v3_s3 || drv_ready;
	assign adv2      = !v2_s2 || adv3;
	assign adv1      = !v1_s1 || adv2;
	assign pop       = q_valid && adv1;
	assign drv_valid = v3_s3;
	assign drv       = drv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (adv1)
				v1_s1 <= q_valid;
			if (adv2)
				v2_s2 <= v1_s1;
			if (adv3)
				v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && q_valid) begin
			p_s1    <= q_cmd.err * $signed({1'b0, gains.prop_gain});
			d_s1    <= q_cmd.yaw * $signed({1'b0, gains.deriv_gain});
			mc_s1   <= MC_BITS'(q_cmd.mag) * MC_BITS'(gains.correction_ratio);
			fwd_s1  <= q_cmd.fwd;
			half_s1 <= q_cmd.half;
			mode_s1 <= q_cmd.mode;
		end
	end

	// Rescale with a floor shift, then cap by the larger of the scaled throttle and
	// the fixed floor; the correction is zero outside heading hold
	always_comb begin
		raw    = RAW_BITS'(p_s1) - RAW_BITS'(d_s1);
		turn_w = (TURN_BITS'(raw) <<< SHL) >>> SHR;
		maxc   = mc_s1[MC_BITS-1:RATIO_FRAC];
		if (maxc < FLOOR_CORR)
			maxc = FLOOR_CORR;
		maxc_w = $signed(TURN_BITS'(maxc));
		if (mode_s1 != MODE_HOLD)
			turn_c = '0;
		else if (turn_w > maxc_w)
			turn_c = CLAMP_BITS'(maxc_w);
		else if (turn_w < -maxc_w)
			turn_c = CLAMP_BITS'(-maxc_w);
		else
			turn_c = CLAMP_BITS'(turn_w);
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_s1) begin
			turn_s2 <= turn_c;
			fwd_s2  <= fwd_s1;
			half_s2 <= half_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Mix, saturate, halve toward zero, negate right side
	always_comb begin
		sum_l = SUM_BITS'(fwd_s2) - SUM_BITS'(turn_s2);
		sum_r = SUM_BITS'(fwd_s2) + SUM_BITS'(turn_s2);
		if (sum_l > SUM_BITS'(FULL_SCALE))
			sat_l = FULL_SCALE;
		else if (sum_l < -SUM_BITS'(FULL_SCALE))
			sat_l = -FULL_SCALE;
		else
			sat_l = THROTTLE_BITS'(sum_l);
		if (sum_r > SUM_BITS'(FULL_SCALE))
			sat_r = FULL_SCALE;
		else if (sum_r < -SUM_BITS'(FULL_SCALE))
			sat_r = -FULL_SCALE;
		else
			sat_r = THROTTLE_BITS'(sum_r);
		if (half_s2) begin
			half_l = $signed(sat_l + THROTTLE_BITS'(sat_l[THROTTLE_BITS-1])) >>> 1;
			half_r = $signed(sat_r + THROTTLE_BITS'(sat_r[THROTTLE_BITS-1])) >>> 1;
		end else begin
			half_l = sat_l;
			half_r = sat_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v2_s2) begin
			drv_s3.left_drive  <= half_l;
			drv_s3.right_drive <= -half_r;
			drv_s3.drive_mode  <= mode_s2;
		end
	end

endmodule

@@ hw/rtl/heading_hold_drive_mixer_unit.sv @@
// Top level of the heading-hold differential drive mixer.
// Holds the configuration registers and joins front, queue and back.
// Uses hhdm_pkg, hhdm_front, hhdm_queue, hhdm_back.

// One item is one control tick. The block takes a new item every clock cycle
// as long as its two-entry command queue has room, and a result is offered on
// drv after the item passes through the queue and the back stages: the front
// classifies the item (deadband, mode machine, target latch) and writes it into
// the queue in the cycle of acceptance, then the back runs three stages - the
// two gain multiplies and the throttle-to-cap multiply, the PD sum with rescale
// and cap, and the left/right mix with saturation, halving and negation into
// the output register. Items with the go-straight button released update the
// mode and give no result. A stall on the result side backs up the pipeline,
// then the queue, and only then drops cmd_ready. Registers are written through
// cfg_we/cfg_index/cfg_data; write them only while no item is in flight.
module heading_hold_drive_mixer_unit
	import hhdm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  hhdm_in_t                  cmd,
	output logic                      drv_valid,
	input  logic                      drv_ready,
	output hhdm_out_t                 drv,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [GAIN_BITS-1:0]     prop_gain_q, deriv_gain_q;
	logic [RATIO_BITS-1:0]    corr_ratio_q;
	logic [DEADBAND_BITS-1:0] deadband_q;
	hhdm_gains_t              gains;
	hhdm_push_t               push;
	hhdm_cmd_t                q_cmd;
	logic                     q_full, q_valid, pop;

	// Configuration registers: take the low bits of the data word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			deriv_gain_q <= '0;
			corr_ratio_q <= CORR_RATIO_RESET;
			deadband_q   <= DEADBAND_RESET;
		end else if (cfg_we) begin
			case (hhdm_cfg_t'(cfg_index))
				CFG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_BITS-1:0];
				CFG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_BITS-1:0];
				CFG_CORR_RATIO: corr_ratio_q <= cfg_data[RATIO_BITS-1:0];
				CFG_DEADBAND:   deadband_q   <= cfg_data[DEADBAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign gains.prop_gain        = prop_gain_q;
	assign gains.deriv_gain       = deriv_gain_q;
	assign gains.correction_ratio = corr_ratio_q;

	// Front: accept and classify items, advance the mode machine
	hhdm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.deadband_level (deadband_q),
		.q_full         (q_full),
		.push           (push)
	);

	// Queue: decouple front from back so each side stalls on its own
	hhdm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.q_full  (q_full),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	// Back: PD correction, cap and drive mixing
	hhdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.gains     (gains),
		.drv_valid (drv_valid),
		.drv_ready (drv_ready),
		.drv       (drv)
	);

endmodule

@@ dv/heading_hold_drive_mixer_unit_test.sv @@
// Self-checking testbench for heading_hold_drive_mixer_unit.
// Drives control ticks, predicts left/right drive and mode, checks each result.
// Depends on hhdm_pkg and the heading_hold_drive_mixer_unit RTL.
module heading_hold_drive_mixer_unit_test;
	import hhdm_pkg::*;

	// Cycles to let results-free items drain before touching a register.
	localparam int SETTLE_CYCLES  = 8;
	// Cycles with no handshake at all before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 400;
	localparam int PHASE_ITEMS    = 240;

	localparam longint DRIVE_FULL = (longint'(1) << TFRAC) - 1;
	// Smallest correction cap: 0.10 of full scale, rounded.
	localparam longint CAP_FLOOR  = ((longint'(1) << TFRAC) + 5) / 10;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cmd_valid = 1'b0;
	logic                      cmd_ready;
	hhdm_in_t                  cmd = '0;
	logic                      drv_valid;
	logic                      drv_ready = 1'b0;
	hhdm_out_t                 drv;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	heading_hold_drive_mixer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.drv_valid (drv_valid),
		.drv_ready (drv_ready),
		.drv       (drv),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Ticks waiting to be sent, and drive results owed by the block.
	hhdm_in_t  tick_q[$];
	hhdm_out_t drive_q[$];

	// Shadow of the register file, kept in step with every write.
	int prop_k  = 0;
	int deriv_k = 0;
	int ratio_k = int'(CORR_RATIO_RESET);
	int db_k    = int'(DEADBAND_RESET);

	// Shadow of the mode machine and the latched heading.
	hhdm_mode_t mode_now   = MODE_OFF;
	longint     target_hdg = 0;

	int mismatch_count = 0;
	int send_gap = 0;
	int recv_stall = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int quiet_cycles = 0;

	hhdm_out_t next_drive;
	bit        next_has;
	hhdm_out_t want;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint limit_span(input longint v, input longint lim);
		if (v < -lim)
			return -lim;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// Advance the mode machine by one tick and work out the drive it gives.
	// has_drive is low when the go-straight button is released.
	function automatic hhdm_out_t mix_drive(input hhdm_in_t tick, output bit has_drive);
		longint    fwd;
		longint    mag;
		longint    err;
		longint    raw;
		longint    cap;
		longint    turn;
		longint    left_v;
		longint    right_v;
		longint    head;
		longint    yaw;
		hhdm_out_t res;

		fwd  = $signed(tick.forward_throttle);
		head = $signed(tick.heading_now);
		yaw  = $signed(tick.yaw_rate);
		// The most negative throttle keeps its full magnitude.
		mag  = (fwd < 0) ? -fwd : fwd;

		// Deadband: at or below the level counts as no throttle.
		if (mag <= longint'(db_k)) begin
			fwd = 0;
			mag = 0;
		end

		case (mode_now)
			MODE_HOLD: begin
				if (!tick.straight_request)
					mode_now = MODE_OFF;
				else if (!tick.sensor_ready)
					mode_now = MODE_SAME;
			end
			// Same throttle sticks until release, even if the sensor comes back.
			MODE_SAME: begin
				if (!tick.straight_request)
					mode_now = MODE_OFF;
			end
			default: begin
				mode_now = MODE_OFF;
				if (tick.straight_request) begin
					if (!tick.sensor_ready) begin
						mode_now = MODE_SAME;
					end else begin
						mode_now   = MODE_HOLD;
						target_hdg = head;
					end
				end
			end
		endcase

		turn = 0;
		if (mode_now == MODE_HOLD) begin
			err = target_hdg - head;
			raw = err * longint'(prop_k) - yaw * longint'(deriv_k);
			// Rescale to throttle units, rounding toward minus infinity.
			turn = raw >>> (RAW_FRAC - TFRAC);
			cap  = (mag * longint'(ratio_k)) >>> RATIO_FRAC;
			if (cap < CAP_FLOOR)
				cap = CAP_FLOOR;
			turn = limit_span(turn, cap);
		end

		// Saturate first, then halve toward zero, then flip the right side.
		left_v  = limit_span(fwd - turn, DRIVE_FULL);
		right_v = limit_span(fwd + turn, DRIVE_FULL);
		if (tick.half_power) begin
			left_v  = left_v / 2;
			right_v = right_v / 2;
		end
		right_v = -right_v;

		res.left_drive  = THROTTLE_BITS'(left_v);
		res.right_drive = THROTTLE_BITS'(right_v);
		res.drive_mode  = mode_now;
		has_drive = tick.straight_request;
		return res;
	endfunction

	function automatic hhdm_in_t make_tick(input int thr, input bit req, input bit half,
			input bit rdy, input int head, input int yaw);
		hhdm_in_t t;

		t.forward_throttle = THROTTLE_BITS'(thr);
		t.straight_request = req;
		t.half_power       = half;
		t.sensor_ready     = rdy;
		t.heading_now      = HEADING_BITS'(head);
		t.yaw_rate         = YAW_BITS'(yaw);
		return t;
	endfunction

	// Write one register at a clock edge and mirror it in the shadow copy.
	task automatic write_reg(input hhdm_cfg_t idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(value);
		case (idx)
			CFG_PROP_GAIN:  prop_k  = value & 16'hFFFF;
			CFG_DERIV_GAIN: deriv_k = value & 16'hFFFF;
			CFG_CORR_RATIO: ratio_k = value & 16'hFFFF;
			CFG_DEADBAND:   db_k    = value & 15'h7FFF;
			default: ;
		endcase
	endtask

	task automatic set_gains(input int p, input int d, input int r, input int db);
		write_reg(CFG_PROP_GAIN, p);
		write_reg(CFG_DERIV_GAIN, d);
		write_reg(CFG_CORR_RATIO, r);
		write_reg(CFG_DEADBAND, db);
		@(posedge clk);
		cfg_we <= 1'b0;
		// Step off the edge so queue pushes never meet the driver's pops.
		@(negedge clk);
	endtask

	// Hold until every tick is sent and every drive result is back, then let
	// ticks that give no result clear the pipeline.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || cmd_valid || drive_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Queue about n random ticks. Most are go-straight runs: enter heading
	// hold, wander near the latched heading, sometimes lose the sensor, then
	// usually release. The rest is raw noise over every bit.
	task automatic add_random(input int n);
		int       cnt;
		int       len;
		int       k;
		int       base;
		int       span;
		int       delta;
		int       thr;
		int       yv;
		int       sel;
		hhdm_in_t t;

		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 9) < 2) begin
				t = $bits(hhdm_in_t)'({$urandom, $urandom});
				tick_q.push_back(t);
				cnt++;
			end else begin
				len  = $urandom_range(2, 24);
				base = $signed(HEADING_BITS'($urandom));
				span = 1 << $urandom_range(2, 24);
				for (k = 0; k < len; k++) begin
					sel = $urandom_range(0, 9);
					if (sel < 3)
						thr = $urandom_range(0, 2 * (db_k + 200)) - (db_k + 200);
					else if (sel == 3)
						thr = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
					else
						thr = $signed(THROTTLE_BITS'($urandom));
					delta = $urandom_range(0, 2 * span) - span;
					yv    = $signed(YAW_BITS'($urandom));
					yv    = yv >>> $urandom_range(0, YAW_BITS - 1);
					tick_q.push_back(make_tick(thr, 1'b1, $urandom_range(0, 1),
						(k == 0) || ($urandom_range(0, 19) != 0), base + delta, yv));
				end
				cnt += len;
				if ($urandom_range(0, 3) != 0) begin
					t = $bits(hhdm_in_t)'({$urandom, $urandom});
					t.straight_request = 1'b0;
					tick_q.push_back(t);
					cnt++;
				end
			end
		end
	endtask

	// Sender: predict on each accepted tick, then present the next one after
	// its drawn gap. Stretches of back-to-back ticks come and go at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				next_drive = mix_drive(cmd, next_has);
				if (next_has)
					drive_q.push_back(next_drive);
			end
			if (!cmd_valid || cmd_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					cmd       <= tick_q.pop_front();
					cmd_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_steady = !send_steady;
					send_gap = send_steady ? 0 : $urandom_range(0, 5);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result against the oldest prediction, then
	// stall for a drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (drv_valid && drv_ready) begin
				if (drive_q.size() == 0) begin
					$error("drive result with none pending: left_drive %0d right_drive %0d drive_mode %0d",
						drv.left_drive, drv.right_drive, drv.drive_mode);
					mismatch_count++;
				end else begin
					want = drive_q.pop_front();
					if (drv.left_drive !== want.left_drive) begin
						$error("left_drive expected %0d actual %0d",
							want.left_drive, drv.left_drive);
						mismatch_count++;
					end
					if (drv.right_drive !== want.right_drive) begin
						$error("right_drive expected %0d actual %0d",
							want.right_drive, drv.right_drive);
						mismatch_count++;
					end
					if (drv.drive_mode !== want.drive_mode) begin
						$error("drive_mode expected %0d actual %0d",
							want.drive_mode, drv.drive_mode);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_steady = !recv_steady;
				recv_stall = recv_steady ? 0 : $urandom_range(0, 5);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				drv_ready <= 1'b0;
			end else begin
				drv_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (drv_valid && drv_ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("heading_hold_drive_mixer_unit test failed");
			$finish;
		end
	end

	initial begin
		int ph;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A few ticks at the reset settings: zero gains, so no correction.
		tick_q.push_back(make_tick(20000, 1'b1, 1'b0, 1'b1, 500, 300));
		tick_q.push_back(make_tick(-20000, 1'b1, 1'b1, 1'b1, -500, -300));
		tick_q.push_back(make_tick(0, 1'b0, 1'b0, 1'b1, 0, 0));
		wait_drained();

		// Directed ticks: deadband edges, every mode change, field extremes.
		set_gains(2000, 500, 32768, 3277);
		tick_q.push_back(make_tick(0, 1'b0, 1'b0, 1'b1, 0, 0));
		// Enter heading hold with a throttle exactly on the deadband.
		tick_q.push_back(make_tick(3277, 1'b1, 1'b0, 1'b1, 1000, 0));
		tick_q.push_back(make_tick(3278, 1'b1, 1'b0, 1'b1, 1640, 0));
		tick_q.push_back(make_tick(-3277, 1'b1, 1'b0, 1'b1, 1000, 6400));
		tick_q.push_back(make_tick(-3278, 1'b1, 1'b0, 1'b1, 360, -6400));
		// Saturate both sides with the largest heading and yaw values.
		tick_q.push_back(make_tick(32767, 1'b1, 1'b0, 1'b1, -8388608, -524288));
		tick_q.push_back(make_tick(-32768, 1'b1, 1'b1, 1'b1, 8388607, 524287));
		tick_q.push_back(make_tick(32767, 1'b1, 1'b1, 1'b1, 1000, 0));
		// Lose the sensor, then get it back: same throttle must stick.
		tick_q.push_back(make_tick(20000, 1'b1, 1'b0, 1'b0, 9000, 100));
		tick_q.push_back(make_tick(-20000, 1'b1, 1'b1, 1'b1, -9000, 100));
		// Release: back to off with no result.
		tick_q.push_back(make_tick(20000, 1'b0, 1'b0, 1'b1, 0, 0));
		// Press with no sensor: straight to same throttle.
		tick_q.push_back(make_tick(15000, 1'b1, 1'b0, 1'b0, 77, 5));
		tick_q.push_back(make_tick(15000, 1'b0, 1'b1, 1'b0, 77, 5));
		// Largest positive and negative heading errors.
		tick_q.push_back(make_tick(30000, 1'b1, 1'b0, 1'b1, 8388607, 0));
		tick_q.push_back(make_tick(-32768, 1'b1, 1'b0, 1'b1, -8388608, 524287));
		tick_q.push_back(make_tick(0, 1'b0, 1'b0, 1'b1, 0, 0));
		tick_q.push_back(make_tick(32767, 1'b1, 1'b0, 1'b1, -8388608, 0));
		tick_q.push_back(make_tick(32767, 1'b1, 1'b0, 1'b1, 8388607, -524288));
		tick_q.push_back(make_tick(-32768, 1'b1, 1'b1, 1'b1, -8388608, 0));
		tick_q.push_back(make_tick(-32768, 1'b0, 1'b1, 1'b0, 0, 0));
		wait_drained();

		// Random phases, each under its own register setting: largest gains and
		// deadband at unity ratio, all zeros, a random setting, one-sided gains, then random settings.
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_gains(65535, 65535, 32768, 32767);
				1: set_gains(0, 0, 0, 0);
				2: set_gains($urandom_range(0, 4000), $urandom_range(0, 2000),
					$urandom_range(0, 32768), $urandom_range(0, 6000));
				3: set_gains(65535, 0, 0, 0);
				4: set_gains(0, 65535, 32768, 3277);
				default: set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 32768), $urandom_range(0, 32767));
			endcase
			add_random(PHASE_ITEMS);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("heading_hold_drive_mixer_unit test passed");
		else
			$display("heading_hold_drive_mixer_unit test failed");
		$finish;
	end

endmodule
